@@ rtl/sct_pkg.sv @@
// Shared types and constants of the size-class table.
package sct_pkg;

  localparam int SIZE_W    = 17;
  localparam int ID_W      = 16;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int POW2_LOW  = 3;
  localparam int POW2_HIGH = 16;

  localparam logic [SIZE_W-1:0] POW2_MIN = SIZE_W'(1) << POW2_LOW;
  localparam logic [SIZE_W-1:0] POW2_TOP = SIZE_W'(1) << POW2_HIGH;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd3;

  localparam logic [CMD_W-1:0] CMD_ROUNDED = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXACT   = 2'd1;

  typedef enum logic [1:0] {
    OP_TOO_LARGE,
    OP_FORCE,
    OP_EXACT,
    OP_ROUNDED
  } op_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] size_a;   // raw or aligned size
    logic [SIZE_W-1:0] size_b;   // power-of-two size, rounded lookups only
  } job_t;

endpackage

@@ rtl/size_class_table.sv @@
// Top level of the allocator size-class lookup and create block.
//
//  channel | dir | tdata                          | tuser
//  in_     | in  | [16:0] request_size            | [1:0] command
//  out_    | out | [15:0] class_id, [32:16] size  | [1:0] status
//
// A rounded lookup that misses searches the back-end table twice, newest first
// (one table read per cycle), on the aligned size and then on the power-of-two size;
// an exact lookup searches once, and a forced create skips the search. The front
// aligns rounded lookups by reciprocal multiply and rounds them up one power-of-two
// step per cycle, overlapped with the back through a two-entry queue.
// Reset clears the fill count and id counter; the table needs no clearing pass.
// A stalled output holds its result while the front keeps taking items until the queue is full and the front holds one.
module size_class_table #(
  parameter int ALIGN_BYTES   = 8,
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_SIZE      = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] request_size
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] class_id, [32:16] class_size
  output logic [1:0]  out_tuser   // [1:0] status
);

  sct_pkg::job_t                  f_job, q_job;
  logic                           f_valid, f_ready, q_valid, q_ready;
  logic [sct_pkg::ID_W-1:0]       res_id;
  logic [sct_pkg::SIZE_W-1:0]     res_size;

  sct_front #(
    .ALIGN_BYTES (ALIGN_BYTES),
    .MAX_SIZE    (MAX_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_size   (in_tdata[sct_pkg::SIZE_W-1:0]),
    .in_cmd    (in_tuser),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  sct_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  sct_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_SIZE      (MAX_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_valid),
    .job_ready  (q_ready),
    .job        (q_job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_id     (res_id),
    .out_size   (res_size),
    .out_status (out_tuser)
  );

  assign out_tdata = {7'd0, res_size, res_id};

endmodule

@@ rtl/sct_front.sv @@
// Front end: accepts requests; for rounded lookups aligns sizes and rounds them to powers of two.
module sct_front #(
  parameter int ALIGN_BYTES = 8,
  parameter int MAX_SIZE    = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sct_pkg::SIZE_W-1:0]    in_size,
  input  logic [sct_pkg::CMD_W-1:0]     in_cmd,
  output logic                          job_valid,
  input  logic                          job_ready,
  output sct_pkg::job_t                 job
);

  // quotient by reciprocal multiply, exact for every 17-bit dividend
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = sct_pkg::SIZE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_V =
    RECIP_W'(((1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES);
  localparam logic [sct_pkg::SIZE_W-1:0] MAX_V   = sct_pkg::SIZE_W'(MAX_SIZE);
  localparam logic [sct_pkg::SIZE_W-1:0] ALIGN_V = sct_pkg::SIZE_W'(ALIGN_BYTES);
  localparam logic [sct_pkg::SIZE_W-1:0] BIAS_V  = sct_pkg::SIZE_W'(ALIGN_BYTES - 1);

  typedef enum logic [2:0] {F_IDLE, F_DIV, F_ALIGN, F_POW, F_PUSH} fstate_t;

  fstate_t                      state_r, state_nxt;
  sct_pkg::job_t                job_r, job_nxt;
  logic [sct_pkg::SIZE_W-1:0]   quot_r, quot_nxt;
  logic [sct_pkg::SIZE_W-1:0]   pow_r, pow_nxt;
  logic [sct_pkg::SIZE_W-1:0]   bumped;
  logic [PROD_W-1:0]            prod;
  logic [sct_pkg::SIZE_W-1:0]   aligned;

  assign in_tready = (state_r == F_IDLE);
  assign job_valid = (state_r == F_PUSH);
  assign job       = job_r;

  assign bumped  = job_r.size_a + BIAS_V;
  assign prod    = PROD_W'(bumped) * PROD_W'(RECIP_V);
  assign aligned = quot_r * ALIGN_V;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    quot_nxt  = quot_r;
    pow_nxt   = pow_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          job_nxt.size_a = in_size;
          job_nxt.size_b = '0;
          priority if (in_size > MAX_V) begin
            job_nxt.op = sct_pkg::OP_TOO_LARGE;
            state_nxt  = F_PUSH;
          end else if (in_cmd[1]) begin
            job_nxt.op = sct_pkg::OP_FORCE;
            state_nxt  = F_PUSH;
          end else if (in_cmd == sct_pkg::CMD_EXACT) begin
            job_nxt.op = sct_pkg::OP_EXACT;
            state_nxt  = F_PUSH;
          end else begin
            job_nxt.op = sct_pkg::OP_ROUNDED;
            state_nxt  = F_DIV;
          end
        end
      end
      F_DIV: begin
        // number of alignment units, rounded up
        quot_nxt  = prod[RECIP_SH +: sct_pkg::SIZE_W];
        state_nxt = F_ALIGN;
      end
      F_ALIGN: begin
        job_nxt.size_a = aligned;
        pow_nxt        = sct_pkg::POW2_MIN;
        if (aligned > MAX_V) begin
          job_nxt.op = sct_pkg::OP_TOO_LARGE;
          state_nxt  = F_PUSH;
        end else begin
          state_nxt = F_POW;
        end
      end
      F_POW: begin
        if (job_r.size_a <= pow_r || pow_r == sct_pkg::POW2_TOP) begin
          job_nxt.size_b = pow_r;
          state_nxt      = F_PUSH;
        end else begin
          pow_nxt = pow_r << 1;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r  <= job_nxt;
    quot_r <= quot_nxt;
    pow_r  <= pow_nxt;
  end

endmodule

@@ rtl/sct_fifo.sv @@
// Two-entry queue of classified requests between front and back.
module sct_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sct_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sct_pkg::job_t pop_job
);

  sct_pkg::job_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/sct_back.sv @@
// Back end: searches the class table newest first, creates classes, drives results.
module sct_back #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_SIZE      = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  sct_pkg::job_t                  job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sct_pkg::ID_W-1:0]       out_id,
  output logic [sct_pkg::SIZE_W-1:0]     out_size,
  output logic [sct_pkg::STATUS_W-1:0]   out_status
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0]           FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [sct_pkg::SIZE_W-1:0] MAX_V    = sct_pkg::SIZE_W'(MAX_SIZE);

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_CREATE, B_DONE} bstate_t;

  typedef struct packed {
    logic [sct_pkg::ID_W-1:0]   id;
    logic [sct_pkg::SIZE_W-1:0] size;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];

  bstate_t                       state_r;
  sct_pkg::job_t                 job_r;
  logic [sct_pkg::SIZE_W-1:0]    key_r;
  logic                          pass_r;
  logic                          iss_r;
  logic [IDX_W-1:0]              addr_r;
  entry_t                        rd_data_r;
  logic                          rd_v_r, rd_last_r;
  logic [CNT_W-1:0]              count_r;
  logic [sct_pkg::ID_W-1:0]      last_id_r;
  logic [sct_pkg::ID_W-1:0]      res_id_r, out_id_r;
  logic [sct_pkg::SIZE_W-1:0]    res_size_r, out_size_r;
  logic [sct_pkg::STATUS_W-1:0]  res_st_r, out_st_r;
  logic                          out_valid_r;

  logic                          hit, miss;
  logic [sct_pkg::ID_W-1:0]      id_new;
  logic [IDX_W-1:0]              top_idx;

  assign job_ready  = (state_r == B_IDLE);
  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_size   = out_size_r;
  assign out_status = out_st_r;

  assign hit     = rd_v_r && (rd_data_r.size == key_r);
  assign miss    = (rd_v_r && rd_last_r && !hit) || (!iss_r && !rd_v_r);
  assign id_new  = last_id_r + 1'b1;
  assign top_idx = IDX_W'(count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (state_r == B_SCAN && iss_r) begin
      rd_data_r <= mem[addr_r];
    end
    if (state_r == B_CREATE && count_r != FULL_CNT) begin
      mem[count_r[IDX_W-1:0]] <= '{id: id_new, size: key_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      iss_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      count_r     <= '0;
      last_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != B_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r     <= job;
            key_r     <= job.size_a;
            pass_r    <= 1'b0;
            rd_v_r    <= 1'b0;
            addr_r    <= top_idx;
            rd_last_r <= 1'b0;
            unique case (job.op)
              sct_pkg::OP_TOO_LARGE: begin
                res_id_r   <= '0;
                res_size_r <= '0;
                res_st_r   <= sct_pkg::ST_TOO_LARGE;
                state_r    <= B_DONE;
              end
              sct_pkg::OP_FORCE: state_r <= B_CREATE;
              default: begin
                iss_r   <= (count_r != '0);
                state_r <= B_SCAN;
              end
            endcase
          end
        end
        B_SCAN: begin
          priority if (hit) begin
            res_id_r   <= rd_data_r.id;
            res_size_r <= rd_data_r.size;
            res_st_r   <= sct_pkg::ST_FOUND;
            iss_r      <= 1'b0;
            rd_v_r     <= 1'b0;
            state_r    <= B_DONE;
          end else if (miss) begin
            rd_v_r <= 1'b0;
            if (job_r.op == sct_pkg::OP_ROUNDED && !pass_r) begin
              if (job_r.size_b > MAX_V) begin
                res_id_r   <= '0;
                res_size_r <= '0;
                res_st_r   <= sct_pkg::ST_TOO_LARGE;
                iss_r      <= 1'b0;
                state_r    <= B_DONE;
              end else begin
                // second search on the power-of-two size
                key_r     <= job_r.size_b;
                pass_r    <= 1'b1;
                iss_r     <= (count_r != '0);
                addr_r    <= top_idx;
                rd_last_r <= 1'b0;
              end
            end else begin
              iss_r   <= 1'b0;
              state_r <= B_CREATE;
            end
          end else begin
            rd_v_r <= iss_r;
            if (iss_r) begin
              rd_last_r <= (addr_r == '0);
              if (addr_r == '0) begin
                iss_r <= 1'b0;
              end else begin
                addr_r <= addr_r - 1'b1;
              end
            end
          end
        end
        B_CREATE: begin
          if (count_r == FULL_CNT) begin
            res_id_r   <= '0;
            res_size_r <= '0;
            res_st_r   <= sct_pkg::ST_FULL;
          end else begin
            last_id_r  <= id_new;
            count_r    <= count_r + 1'b1;
            res_id_r   <= id_new;
            res_size_r <= key_r;
            res_st_r   <= sct_pkg::ST_CREATED;
          end
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_id_r    <= res_id_r;
            out_size_r  <= res_size_r;
            out_st_r    <= res_st_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CREATE && count_r != FULL_CNT) |=>
      (last_id_r == $past(last_id_r) + 1'b1) && (count_r == $past(count_r) + 1'b1))
    else $error("create did not advance id and count together");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == sct_pkg::ST_FULL || out_st_r == sct_pkg::ST_TOO_LARGE))
      |-> (out_id_r == '0 && out_size_r == '0))
    else $error("error result carries nonzero id or size");

  a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_r || rd_v_r) |-> (state_r == B_SCAN))
    else $error("table read outside a search");

endmodule
